FILE: sv/gpsm_pkg.sv
`timescale 1ns / 1ps
package gpsm_pkg;

  // Operation carried by one input beat
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  // Configuration register indexes
  localparam logic CFG_FIRST_SIX  = 1'b0;
  localparam logic CFG_SECOND_SIX = 1'b1;

  localparam int unsigned SEL_BIT      = 6;
  localparam logic [7:0] LATCH_RESET   = 8'h60;
  localparam logic [7:0] BLOCK_MASK    = 8'h0C;
  localparam logic [7:0] BLOCKED_VALUE = 8'h7F;
  localparam logic [4:0] IDLE_LIMIT    = 5'd25;

  // Per-port update request from the datapath
  typedef struct packed {
    logic       wr;
    logic       tick;
    logic [7:0] data;
  } port_cmd_t;

endpackage

FILE: sv/gamepad_port_select_multiplexer_core.sv
`timescale 1ns / 1ps
// Pipeline: each beat passes the input register, then the result register.
// Throughput: one beat per cycle while out_tready is high; port state is updated as a
// beat moves into the result register, so each beat sees the state left by the one before it.
// Reset (rst_n, synchronous, active low): both latches 0x60, phases and idle
// counters 0, six-button flags 0, both pipeline stages empty.
module gamepad_port_select_multiplexer_core
  import gpsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // mode[1:0], port[2], write_data[10:3], buttons[22:11], pad
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // read_data[7:0]
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_wdata
);

  logic        first_six_r, second_six_r;
  logic        s1_valid_r;
  logic [1:0]  s1_mode_r;
  logic        s1_port_r;
  logic [7:0]  s1_data_r;
  logic [11:0] s1_btn_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        advance;
  mode_t       mode;
  port_cmd_t   cmd0, cmd1;
  logic [7:0]  latch0, latch1;
  logic [1:0]  phase0, phase1;
  logic [4:0]  idle0, idle1;
  logic [7:0]  rd0, rd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_six_r  <= 1'b0;
      second_six_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FIRST_SIX:  first_six_r  <= cfg_wdata;
        CFG_SECOND_SIX: second_six_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign mode      = mode_t'(s1_mode_r);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= in_tdata[1:0];
      s1_port_r <= in_tdata[2];
      s1_data_r <= in_tdata[10:3];
      s1_btn_r  <= in_tdata[22:11];
    end
  end

  // per-port update requests
  always_comb begin
    cmd0.wr   = advance && (mode == MODE_WRITE) && !s1_port_r;
    cmd0.tick = advance && (mode == MODE_TICK);
    cmd0.data = s1_data_r;
    cmd1.wr   = advance && (mode == MODE_WRITE) && s1_port_r;
    cmd1.tick = advance && (mode == MODE_TICK);
    cmd1.data = s1_data_r;
  end

  gpsm_port_state u_port0 (
    .clk(clk), .rst_n(rst_n), .cmd(cmd0),
    .latch(latch0), .phase(phase0), .idle(idle0)
  );

  gpsm_port_state u_port1 (
    .clk(clk), .rst_n(rst_n), .cmd(cmd1),
    .latch(latch1), .phase(phase1), .idle(idle1)
  );

  gpsm_pad_read u_read0 (
    .latch(latch0), .six_button(first_six_r), .phase(phase0),
    .buttons(s1_btn_r), .read_data(rd0)
  );

  gpsm_pad_read u_read1 (
    .latch(latch1), .six_button(second_six_r), .phase(phase1),
    .buttons(s1_btn_r), .read_data(rd1)
  );

  // result selection
  always_comb begin
    case (mode)
      MODE_READ: begin
        if (!s1_port_r) begin
          out_data_nxt = rd0;
        end else if ((latch1 & BLOCK_MASK) != 8'h00) begin
          out_data_nxt = BLOCKED_VALUE;
        end else begin
          out_data_nxt = rd1;
        end
      end
      MODE_WRITE: out_data_nxt = s1_data_r;
      default:    out_data_nxt = 8'h00;
    endcase
  end

  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_idle_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (idle0 <= IDLE_LIMIT + 5'd1) && (idle1 <= IDLE_LIMIT + 5'd1))
    else $error("idle counter above saturation");

  a_tick_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd0.tick && (idle0 > IDLE_LIMIT)) |=> (phase0 == 2'd0))
    else $error("expired tick did not clear phase");

  a_write_latches: assert property (@(posedge clk) disable iff (!rst_n)
    cmd1.wr |=> (latch1 == $past(s1_data_r)) && (idle1 == 5'd0))
    else $error("write did not update second port");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in pipeline");

endmodule

FILE: sv/gpsm_pad_read.sv
`timescale 1ns / 1ps
module gpsm_pad_read
  import gpsm_pkg::*;
(
  input  logic [7:0]  latch,
  input  logic        six_button,
  input  logic [1:0]  phase,
  input  logic [11:0] buttons,
  output logic [7:0]  read_data
);

  logic [2:0] sel;
  logic [1:0] sa;

  // low bit from the select line, upper bits from the phase on six-button pads
  assign sel = {(six_button ? phase : 2'b00), latch[SEL_BIT]};
  // start on bit 5, A on bit 4
  assign sa  = {buttons[4], buttons[5]};

  always_comb begin
    case (sel)
      3'd1, 3'd3, 3'd5: read_data = {2'b01, buttons[7], buttons[6], buttons[3:0]};
      3'd0, 3'd2:       read_data = {2'b00, sa, 2'b00, buttons[1:0]};
      3'd4:             read_data = {2'b00, sa, 4'h0};
      3'd6:             read_data = {2'b00, sa, 4'hF};
      default: begin
        read_data = {2'b01, buttons[7], buttons[6],
                     buttons[8], buttons[9], buttons[10], buttons[11]};
      end
    endcase
  end

endmodule

FILE: sv/gpsm_port_state.sv
`timescale 1ns / 1ps
module gpsm_port_state
  import gpsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  port_cmd_t  cmd,
  output logic [7:0] latch,
  output logic [1:0] phase,
  output logic [4:0] idle
);

  logic [7:0] latch_r, latch_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [4:0] idle_r,  idle_nxt;

  // write: rising select advances phase; tick: idle count saturates, then phase clears
  always_comb begin
    latch_nxt = latch_r;
    phase_nxt = phase_r;
    idle_nxt  = idle_r;
    if (cmd.wr) begin
      if (!latch_r[SEL_BIT] && cmd.data[SEL_BIT]) begin
        phase_nxt = phase_r + 2'd1;
      end
      idle_nxt  = '0;
      latch_nxt = cmd.data;
    end else if (cmd.tick) begin
      if (idle_r <= IDLE_LIMIT) begin
        idle_nxt = idle_r + 5'd1;
      end else begin
        phase_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= LATCH_RESET;
      phase_r <= '0;
      idle_r  <= '0;
    end else begin
      latch_r <= latch_nxt;
      phase_r <= phase_nxt;
      idle_r  <= idle_nxt;
    end
  end

  assign latch = latch_r;
  assign phase = phase_r;
  assign idle  = idle_r;

endmodule

FILE: tb/sv/tb_gamepad_port_select_multiplexer_core.sv
`timescale 1ns / 1ps
module tb_gamepad_port_select_multiplexer_core;
  import gpsm_pkg::*;

  // Mode value outside the defined operations; the block must ignore it
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 12;
  localparam int unsigned LIMIT_CYCLES  = 200000;

  typedef enum logic {
    ROW_BEAT = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  // One row of the directed table: either a register write or an input beat
  typedef struct packed {
    row_kind_t   kind;
    logic        cfg_idx;
    logic        cfg_val;
    logic [1:0]  mode;
    logic        port;
    logic [7:0]  data;
    logic [11:0] buttons;
    logic        typed;
    logic [7:0]  want;
  } row_t;

  localparam row_t DIRECTED [0:24] = '{
    // reset state, select high, no six-button pads
    '{ROW_BEAT, 1'b0, 1'b0, MODE_READ,  1'b0, 8'h00, 12'hFFF, 1'b1, 8'h7F},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_READ,  1'b0, 8'h00, 12'h000, 1'b1, 8'h40},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b0, 8'h00, 12'h000, 1'b1, 8'h00},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_READ,  1'b0, 8'h00, 12'hFFF, 1'b1, 8'h33},
    // second port blocked by latch bits 2..3
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b1, 8'h0C, 12'hFFF, 1'b1, 8'h0C},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_READ,  1'b1, 8'h00, 12'hFFF, 1'b1, 8'h7F},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b1, 8'h40, 12'h000, 1'b1, 8'h40},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_READ,  1'b1, 8'h00, 12'h000, 1'b1, 8'h40},
    // tick and unused mode both return zero
    '{ROW_BEAT, 1'b0, 1'b0, MODE_TICK,  1'b0, 8'hFF, 12'hFFF, 1'b1, 8'h00},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_SPARE, 1'b1, 8'hFF, 12'hFFF, 1'b1, 8'h00},
    // six-button pad on the first port: walk the phase through all values
    '{ROW_CFG,  CFG_FIRST_SIX, 1'b1, MODE_READ, 1'b0, 8'h00, 12'h000, 1'b0, 8'h00},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b0, 8'h40, 12'h000, 1'b1, 8'h40},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b0, 8'h00, 12'h000, 1'b1, 8'h00},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b0, 8'h40, 12'h000, 1'b1, 8'h40},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b0, 8'h00, 12'h000, 1'b1, 8'h00},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_READ,  1'b0, 8'h00, 12'hFFF, 1'b1, 8'h30},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b0, 8'h40, 12'h000, 1'b1, 8'h40},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_READ,  1'b0, 8'h00, 12'h000, 1'b1, 8'h40},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b0, 8'h00, 12'h000, 1'b1, 8'h00},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_READ,  1'b0, 8'h00, 12'h000, 1'b1, 8'h0F},
    // phase wraps from 3 back to 0
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b0, 8'hFF, 12'h000, 1'b1, 8'hFF},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_READ,  1'b0, 8'h00, 12'hAAA, 1'b0, 8'h00},
    // six-button pad on the second port
    '{ROW_CFG,  CFG_SECOND_SIX, 1'b1, MODE_READ, 1'b0, 8'h00, 12'h000, 1'b0, 8'h00},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_READ,  1'b1, 8'h00, 12'h5A5, 1'b0, 8'h00},
    '{ROW_BEAT, 1'b0, 1'b0, MODE_WRITE, 1'b1, 8'h8C, 12'h000, 1'b1, 8'h8C}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // mode[1:0], port[2], write_data[10:3], buttons[22:11], pad
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // read_data[7:0]
  logic        cfg_we;
  logic        cfg_addr;
  logic        cfg_wdata;

  // Port state as the block should hold it
  logic [7:0] latch_q [2];
  logic [1:0] phase_q [2];
  logic [4:0] idle_q  [2];
  logic       six_button [2];

  logic [7:0]  expected_bytes [$];
  logic [7:0]  head_byte;
  int unsigned beats_sent;
  int unsigned results_checked;
  int unsigned phase_clears;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left;
  bit          calm;

  gamepad_port_select_multiplexer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Button byte on the pad lines for a given latch, pad kind and phase
  function automatic logic [7:0] pad_lines(input logic [7:0] latch, input logic six,
                                           input logic [1:0] phase, input logic [11:0] b);
    logic [2:0] sel;
    logic [7:0] sa;
    sel = {2'b00, latch[SEL_BIT]} + (six ? {phase, 1'b0} : 3'd0);
    sa  = {2'b00, b[4], b[5], 4'b0000};
    case (sel)
      3'd1, 3'd3, 3'd5: pad_lines = {2'b01, b[7], b[6], b[3:0]};
      3'd0, 3'd2:       pad_lines = sa | {6'b000000, b[1:0]};
      3'd4:             pad_lines = sa;
      3'd6:             pad_lines = sa | 8'h0F;
      default:          pad_lines = {2'b01, b[7], b[6], b[8], b[9], b[10], b[11]};
    endcase
  endfunction

  // Applies one beat to the port state, returns the byte the block must answer
  function automatic logic [7:0] apply_beat(input logic [1:0] mode, input logic port,
                                            input logic [7:0] data, input logic [11:0] b);
    logic [7:0] r;
    r = 8'h00;
    case (mode)
      MODE_READ: begin
        if (port && (latch_q[1] & BLOCK_MASK) != 8'h00)
          r = BLOCKED_VALUE;
        else
          r = pad_lines(latch_q[port], six_button[port], phase_q[port], b);
      end
      MODE_WRITE: begin
        // rising select line steps the phase
        if (!latch_q[port][SEL_BIT] && data[SEL_BIT])
          phase_q[port] = phase_q[port] + 2'd1;
        idle_q[port]  = 5'd0;
        latch_q[port] = data;
        r = data;
      end
      MODE_TICK: begin
        for (int p = 0; p < 2; p++) begin
          if (idle_q[p] <= IDLE_LIMIT) begin
            idle_q[p] = idle_q[p] + 5'd1;
          end else begin
            if (phase_q[p] != 2'd0)
              phase_clears++;
            phase_q[p] = 2'd0;
          end
        end
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Presents one beat, waits for the handshake and records the expected answer
  task automatic send_beat(input logic [1:0] mode, input logic port, input logic [7:0] data,
                           input logic [11:0] buttons, input logic typed,
                           input logic [7:0] want);
    logic [7:0] predicted;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(negedge clk);
    end
    in_tdata  <= {1'b0, buttons, data, port, mode};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = apply_beat(mode, port, data, buttons);
    expected_bytes.push_back(typed ? want : predicted);
    beats_sent++;
    @(negedge clk);
  endtask

  // Register write with the pipeline empty
  task automatic set_pad_kind(input logic idx, input logic val);
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    six_button[idx] = val;
  endtask

  // Mostly select-line handshakes, plus tick bursts and free-form noise
  task automatic run_random_phase(input logic six0, input logic six1,
                                  input int unsigned beats, input int unsigned gap,
                                  input int unsigned stall, input bit quiet);
    int unsigned stop_at;
    int unsigned k;
    int unsigned toggles;
    int unsigned n;
    logic        p;
    logic [7:0]  d;
    logic [1:0]  m;
    set_pad_kind(CFG_FIRST_SIX, six0);
    set_pad_kind(CFG_SECOND_SIX, six1);
    gap_pct   = gap;
    stall_pct = stall;
    calm      = quiet;
    stop_at   = beats_sent + beats;
    while (beats_sent < stop_at) begin
      k = $urandom_range(99);
      p = 1'($urandom_range(1));
      if (k < 60) begin
        // toggle select low/high, reading in between; mostly leave port two unblocked
        toggles = $urandom_range(4, 1);
        for (int j = 0; j < 2 * toggles; j++) begin
          d = 8'($urandom_range(255));
          d[SEL_BIT] = (j % 2 == 1);
          if ($urandom_range(9) != 0)
            d = d & ~BLOCK_MASK;
          send_beat(MODE_WRITE, p, d, 12'($urandom_range(4095)), 1'b0, 8'h00);
          repeat ($urandom_range(2)) begin
            send_beat(MODE_READ, p, 8'($urandom_range(255)), 12'($urandom_range(4095)),
                      1'b0, 8'h00);
          end
        end
      end else if (k < 75) begin
        // tick bursts, some long enough to run the idle counters out and clear the phase
        n = ($urandom_range(2) == 0) ? $urandom_range(32, 26) : $urandom_range(4, 1);
        repeat (n) begin
          send_beat(MODE_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    12'($urandom_range(4095)), 1'b0, 8'h00);
        end
        send_beat(MODE_READ, p, 8'($urandom_range(255)), 12'($urandom_range(4095)),
                  1'b0, 8'h00);
      end else begin
        m = ($urandom_range(19) == 0) ? MODE_SPARE : 2'($urandom_range(2));
        send_beat(m, p, 8'($urandom_range(255)), 12'($urandom_range(4095)), 1'b0, 8'h00);
      end
    end
  endtask

  // Result side back-pressure
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        stall_left = 0;
        out_tready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(14, 1) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("read_data: expected nothing, actual 0x%02h", out_tdata);
        mismatches++;
      end else begin
        head_byte = expected_bytes.pop_front();
        if (out_tdata !== head_byte) begin
          $error("read_data: expected 0x%02h, actual 0x%02h", head_byte, out_tdata);
          mismatches++;
        end
        results_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = 1'b0;
    cfg_wdata  = 1'b0;
    gap_pct    = 0;
    stall_pct  = 0;
    calm       = 1'b0;
    beats_sent = 0;
    results_checked = 0;
    phase_clears    = 0;
    mismatches      = 0;
    cycles          = 0;
    for (int p = 0; p < 2; p++) begin
      latch_q[p]    = LATCH_RESET;
      phase_q[p]    = 2'd0;
      idle_q[p]     = 5'd0;
      six_button[p] = 1'b0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    gap_pct   = 25;
    stall_pct = 25;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG)
        set_pad_kind(DIRECTED[i].cfg_idx, DIRECTED[i].cfg_val);
      else
        send_beat(DIRECTED[i].mode, DIRECTED[i].port, DIRECTED[i].data,
                  DIRECTED[i].buttons, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // random phases across the pad kinds; the last one runs at full rate
    run_random_phase(1'b1, 1'b1, 220, 30, 30, 1'b0);
    run_random_phase(1'b0, 1'b0, 150, 0, 0, 1'b0);
    run_random_phase(1'b1, 1'b0, 220, 50, 15, 1'b0);
    run_random_phase(1'b0, 1'b1, 220, 15, 50, 1'b0);
    run_random_phase(1'b1, 1'b1, 220, 0, 0, 1'b1);

    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d beats over both pad kinds on each port, %0d results checked,",
             beats_sent, results_checked);
    $display("%0d phase clears by idle timeout, %0d mismatches", phase_clears, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
